// ===== src/hbr_pkg.sv =====
`timescale 1ns / 1ps

package hbr_pkg;

	// Number of bisection steps, one pipeline stage each
	localparam int BISECT_STEPS = 30;

	// Accumulator width: grey term below 2^(N+16), step term below 2^(N+17), plus sign
	localparam int ACC_W = BISECT_STEPS + 19;

	// Width of the luma sum and of a channel direction (magnitude below 2^17)
	localparam int SUM_W = 18;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [8:0]       diff_t;

	// Fit window: -255*2^N < num < 256*255*2^N
	localparam acc_t DEN     = ACC_W'({8'd255, {BISECT_STEPS{1'b0}}});
	localparam acc_t NEG_DEN = -DEN;
	localparam acc_t LIM     = ACC_W'({8'd255, {(BISECT_STEPS + 8){1'b0}}});

	typedef struct packed {
		logic [7:0] hue_index;
		logic [7:0] brightness;
	} hue_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// One bisection stage's beat: numerator at the last fitting rate, and next increment
	typedef struct packed {
		acc_t [2:0] acc;
		acc_t [2:0] inc;
	} step_t;

	localparam logic [7:0] RAMP_UP [0:42] = '{
		8'd0, 8'd6, 8'd12, 8'd18, 8'd24, 8'd30, 8'd36, 8'd43, 8'd49, 8'd55, 8'd61,
		8'd67, 8'd73, 8'd79, 8'd85, 8'd91, 8'd97, 8'd103, 8'd109, 8'd115, 8'd121,
		8'd128, 8'd134, 8'd140, 8'd146, 8'd152, 8'd158, 8'd164, 8'd170, 8'd176,
		8'd182, 8'd188, 8'd194, 8'd200, 8'd206, 8'd214, 8'd219, 8'd225, 8'd231,
		8'd237, 8'd243, 8'd249, 8'd255
	};

	localparam logic [7:0] RAMP_DOWN [0:42] = '{
		8'd250, 8'd244, 8'd238, 8'd232, 8'd226, 8'd220, 8'd213, 8'd208, 8'd202,
		8'd196, 8'd190, 8'd184, 8'd178, 8'd172, 8'd166, 8'd160, 8'd154, 8'd148,
		8'd142, 8'd136, 8'd130, 8'd125, 8'd119, 8'd113, 8'd107, 8'd101, 8'd95,
		8'd89, 8'd83, 8'd77, 8'd71, 8'd65, 8'd59, 8'd53, 8'd47, 8'd42, 8'd36,
		8'd30, 8'd24, 8'd18, 8'd12, 8'd6, 8'd0
	};

	localparam logic [7:0] RAMP_TAIL [0:4] = '{8'd25, 8'd20, 8'd15, 8'd10, 8'd5};

	// Saturated colour of the wheel at a hue
	function automatic rgb_t wheel_rom(input logic [7:0] idx);
		rgb_t       c;
		logic [7:0] off;
		logic [7:0] off2;
		c    = '0;
		off  = 8'd0;
		off2 = 8'd0;
		if (idx < 8'd43) begin
			c.red   = 8'd0;
			c.green = 8'd255;
			c.blue  = RAMP_UP[idx[5:0]];
		end else if (idx < 8'd86) begin
			off     = idx - 8'd43;
			c.red   = 8'd0;
			c.green = RAMP_DOWN[off[5:0]];
			c.blue  = 8'd255;
		end else if (idx < 8'd128) begin
			off     = idx - 8'd85;
			c.red   = RAMP_UP[off[5:0]];
			c.green = 8'd0;
			c.blue  = 8'd255;
		end else if (idx < 8'd171) begin
			off     = idx - 8'd128;
			c.red   = 8'd255;
			c.green = 8'd0;
			c.blue  = RAMP_DOWN[off[5:0]];
		end else if (idx < 8'd213) begin
			off     = idx - 8'd170;
			c.red   = 8'd255;
			c.green = RAMP_UP[off[5:0]];
			c.blue  = 8'd0;
		end else begin
			off = idx - 8'd213;
			if (off < 8'd38) begin
				c.red = RAMP_DOWN[off[5:0]];
			end else begin
				off2  = off - 8'd38;
				c.red = RAMP_TAIL[off2[2:0]];
			end
			c.green = 8'd255;
			c.blue  = 8'd0;
		end
		return c;
	endfunction

endpackage

// ===== src/hbr_step.sv =====
`timescale 1ns / 1ps

module hbr_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid,
	input  hbr_pkg::step_t data,
	output logic           valid_s1,
	output hbr_pkg::step_t data_s1
);
	import hbr_pkg::*;

	acc_t  cand [3];
	logic  fit;
	step_t nxt;

	// Try the midpoint rate; keep it only if all three channels land in range
	always_comb begin
		fit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			cand[i] = $signed(data.acc[i]) + $signed(data.inc[i]);
			if (!(cand[i] > NEG_DEN && cand[i] < LIM)) begin
				fit = 1'b0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			nxt.acc[i] = fit ? cand[i] : $signed(data.acc[i]);
			nxt.inc[i] = $signed(data.inc[i]) >>> 1;
		end
	end

	// Advance the beat when the pipeline moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== src/hue_brightness_to_rgb.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle unless a full output queue holds the pipeline;
// three front stages, one stage per bisection step.
// A two-entry output queue lets the pipeline keep taking beats while a result waits.
// Reset clears valid bits, queue pointers and count only; data and queue memory are not reset.
module hue_brightness_to_rgb (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hue_valid,
	output logic          hue_ready,
	input  hbr_pkg::hue_t hue_data,
	output logic          rgb_valid,
	input  logic          rgb_ready,
	output hbr_pkg::rgb_t rgb_data
);
	import hbr_pkg::*;

	logic en;

	// Stage 1: wheel lookup
	logic       valid_s1;
	rgb_t       col_s1;
	logic [7:0] y_s1;

	// Stage 2: channel offsets from grey and luma sum
	logic       valid_s2;
	diff_t      d_s2 [3];
	sum_t       s_s2;
	logic [7:0] y_s2;

	// Stage 3 feeds the bisection chain
	logic  valid_s3;
	step_t step_s3;

	logic  chain_valid [BISECT_STEPS+1];
	step_t chain_data  [BISECT_STEPS+1];

	// Output queue
	rgb_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	logic       full;
	rgb_t       result;

	diff_t d_c [3];
	sum_t  s_c;
	step_t step_c;
	sum_t  dir_c [3];
	logic [15:0] y255_c;

	// Truncate numerator / (255 * 2^N) toward zero, clamping negatives to zero
	function automatic logic [7:0] to_channel(input acc_t a);
		logic [15:0] v;
		logic [16:0] t;
		v = a[BISECT_STEPS+15:BISECT_STEPS];
		t = 17'(v) + 17'(v[15:8]) + 17'd1;
		return a[ACC_W-1] ? 8'd0 : t[15:8];
	endfunction

	// Hold the pipeline only when the last stage holds a beat the queue cannot take
	assign full      = count_q[1];
	assign en        = !chain_valid[BISECT_STEPS] || !full;
	assign hue_ready = en;

	// Valid registers of stages 1 to 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= hue_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= wheel_rom(hue_data.hue_index);
			y_s1   <= hue_data.brightness;
		end
	end

	// Offsets from grey and weighted luma sum
	always_comb begin
		d_c[0] = $signed({1'b0, col_s1.red})   - $signed({1'b0, y_s1});
		d_c[1] = $signed({1'b0, col_s1.green}) - $signed({1'b0, y_s1});
		d_c[2] = $signed({1'b0, col_s1.blue})  - $signed({1'b0, y_s1});
		s_c = SUM_W'(d_c[0]) * 18'sd76 + SUM_W'(d_c[1]) * 18'sd151
			+ SUM_W'(d_c[2]) * 18'sd28;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= d_c;
			s_s2 <= s_c;
			y_s2 <= y_s1;
		end
	end

	// Directions and starting numerator (grey, rate zero)
	always_comb begin
		y255_c = 16'(y_s2) * 16'd255;
		for (int i = 0; i < 3; i++) begin
			dir_c[i]       = SUM_W'(d_s2[i]) * 18'sd255 - s_s2;
			step_c.acc[i]  = ACC_W'({y255_c, {BISECT_STEPS{1'b0}}});
			step_c.inc[i]  = ACC_W'(dir_c[i]) <<< (BISECT_STEPS - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s3 <= step_c;
		end
	end

	assign chain_valid[0] = valid_s3;
	assign chain_data[0]  = step_s3;

	// Bisection chain, one step per stage
	for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
		hbr_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid    (chain_valid[k]),
			.data     (chain_data[k]),
			.valid_s1 (chain_valid[k+1]),
			.data_s1  (chain_data[k+1])
		);
	end

	// Convert the last fitting numerator to channels
	always_comb begin
		result.red   = to_channel($signed(chain_data[BISECT_STEPS].acc[0]));
		result.green = to_channel($signed(chain_data[BISECT_STEPS].acc[1]));
		result.blue  = to_channel($signed(chain_data[BISECT_STEPS].acc[2]));
	end

	assign push      = chain_valid[BISECT_STEPS] && !full;
	assign pop       = rgb_valid && rgb_ready;
	assign rgb_valid = (count_q != 2'd0);
	assign rgb_data  = mem_q[rd_ptr_q];

	// Queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Write the result beat into the queue
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= result;
		end
	end

endmodule
